/* hdl/slpg_pkg.sv */
// shared types, constants and the pattern table for the status led pattern generator
// no dependencies; imported by every module of the block
package slpg_pkg;

   localparam int unsigned TICKS_W = 16;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned DATA_BYTES_W = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_DOUBLE_PULSE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOUBLE_GAP = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAULT_FIRST = 2'd2;

   localparam logic [TICKS_W-1:0] DOUBLE_PULSE_RESET = 16'd70;
   localparam logic [TICKS_W-1:0] DOUBLE_GAP_RESET = 16'd70;
   localparam logic [TICKS_W-1:0] FAULT_FIRST_RESET = 16'd50;

   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_SET = 1'b1;

   localparam logic [2:0] PAT_INIT = 3'd0;
   localparam logic [2:0] PAT_IDLE = 3'd1;
   localparam logic [2:0] PAT_OPENING = 3'd2;
   localparam logic [2:0] PAT_OPEN = 3'd3;
   localparam logic [2:0] PAT_CLOSING = 3'd4;
   localparam logic [2:0] PAT_REVERSING = 3'd5;
   localparam logic [2:0] PAT_STOPPED = 3'd6;

   localparam logic [1:0] PHASE_PULSE1 = 2'd0;
   localparam logic [1:0] PHASE_GAP = 2'd1;
   localparam logic [1:0] PHASE_PULSE2 = 2'd2;
   localparam logic [1:0] PHASE_LONG_GAP = 2'd3;

   typedef struct packed {
      logic       req_type;
      logic [3:0] door_state;
      logic       fault_flag;
   } item_type;

   typedef struct packed {
      logic [TICKS_W-1:0] double_pulse_ticks;
      logic [TICKS_W-1:0] double_gap_ticks;
      logic [TICKS_W-1:0] fault_first_pulse_ticks;
   } cfg_type;

   typedef struct packed {
      logic [TICKS_W-1:0] lit;
      logic [TICKS_W-1:0] dark;
      logic               twin;
   } pat_entry_type;

   function automatic pat_entry_type pat_lookup(input logic [2:0] idx);
      pat_entry_type e;
      case (idx)
         PAT_INIT: e = '{lit: 16'd60, dark: 16'd60, twin: 1'b1};
         PAT_IDLE: e = '{lit: 16'd0, dark: 16'd0, twin: 1'b0};
         PAT_OPENING: e = '{lit: 16'hFFFF, dark: 16'd0, twin: 1'b0};
         PAT_OPEN: e = '{lit: 16'd500, dark: 16'd500, twin: 1'b0};
         PAT_CLOSING: e = '{lit: 16'd125, dark: 16'd125, twin: 1'b0};
         PAT_REVERSING: e = '{lit: 16'd125, dark: 16'd125, twin: 1'b0};
         PAT_STOPPED: e = '{lit: 16'd80, dark: 16'd80, twin: 1'b1};
         default: e = '{lit: 16'd80, dark: 16'd80, twin: 1'b1};
      endcase
      return e;
   endfunction

   function automatic logic [2:0] door_to_pattern(input logic [3:0] door);
      logic [2:0] idx;
      if (door > {1'b0, PAT_STOPPED}) begin
         idx = PAT_STOPPED;
      end else begin
         idx = door[2:0];
      end
      return idx;
   endfunction

endpackage

/* hdl/slpg_csr.sv */
// configuration registers: pulse, gap and faulted first pulse lengths
// depends on slpg_pkg
module slpg_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [slpg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [slpg_pkg::TICKS_W-1:0]   csr_wdata,
   output slpg_pkg::cfg_type              cfg
);
   import slpg_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DOUBLE_PULSE: cfg_in.double_pulse_ticks = csr_wdata;
            CSR_DOUBLE_GAP: cfg_in.double_gap_ticks = csr_wdata;
            CSR_FAULT_FIRST: cfg_in.fault_first_pulse_ticks = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.double_pulse_ticks <= DOUBLE_PULSE_RESET;
         cfg_ff.double_gap_ticks <= DOUBLE_GAP_RESET;
         cfg_ff.fault_first_pulse_ticks <= FAULT_FIRST_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hdl/slpg_in_reg.sv */
// input register: holds one accepted request transaction until the pattern stage takes it
// depends on slpg_pkg
module slpg_in_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  slpg_pkg::item_type req_item,
   output logic               item_valid,
   output slpg_pkg::item_type item,
   input  logic               item_take
);
   import slpg_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     load;

   assign req_tready = !valid_ff || item_take;
   assign load = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (item_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item = item_ff;

endmodule

/* hdl/slpg_pattern.sv */
// pattern state, next-state logic and the result register
// depends on slpg_pkg
module slpg_pattern (
   input  logic               clock,
   input  logic               reset,
   input  slpg_pkg::cfg_type  cfg,
   input  logic               item_valid,
   input  slpg_pkg::item_type item,
   output logic               item_take,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_led
);
   import slpg_pkg::*;

   logic               pvalid_ff, pvalid_in;
   logic [2:0]         index_ff, index_in;
   logic [1:0]         phase_ff, phase_in;
   logic [TICKS_W-1:0] remaining_ff, remaining_in;
   logic               fault_ff, fault_in;
   logic               led_ff, led_in;
   logic               out_valid_ff, out_valid_in;
   logic               out_led_ff;

   logic [2:0]         set_idx;
   logic               changed;
   pat_entry_type      set_e;
   pat_entry_type      tick_e;
   logic [1:0]         step_phase;

   assign item_take = item_valid && (!out_valid_ff || rsp_ready);
   assign set_idx = door_to_pattern(item.door_state);
   assign set_e = pat_lookup(set_idx);
   assign tick_e = pat_lookup(index_ff);
   assign changed = !pvalid_ff || (set_idx != index_ff) || (item.fault_flag != fault_ff);

   always_comb begin
      pvalid_in = pvalid_ff;
      index_in = index_ff;
      phase_in = phase_ff;
      remaining_in = remaining_ff;
      fault_in = fault_ff;
      led_in = led_ff;
      step_phase = phase_ff + 2'd1;
      if (item_take) begin
         if (item.req_type == REQ_SET) begin
            fault_in = item.fault_flag;
            if (changed) begin
               pvalid_in = 1'b1;
               index_in = set_idx;
               if (set_e.lit == '0) begin
                  phase_in = PHASE_GAP;
                  remaining_in = '0;
                  led_in = 1'b0;
               end else begin
                  phase_in = PHASE_PULSE1;
                  remaining_in = set_e.twin ? cfg.double_pulse_ticks : set_e.lit;
                  led_in = 1'b1;
               end
               if (item.fault_flag && (set_idx == PAT_STOPPED)) begin
                  phase_in = PHASE_PULSE1;
                  remaining_in = cfg.fault_first_pulse_ticks;
                  led_in = 1'b1;
               end
            end
         end else if (pvalid_ff) begin
            if ((tick_e.lit == '0) || ((tick_e.dark == '0) && !tick_e.twin)) begin
               if ((tick_e.lit != '0) && (tick_e.dark == '0)) begin
                  led_in = 1'b1;
               end
            end else if (remaining_ff != '0) begin
               remaining_in = remaining_ff - 16'd1;
            end else if (!tick_e.twin) begin
               phase_in = phase_ff ^ 2'd1;
               if ((phase_ff ^ 2'd1) == PHASE_PULSE1) begin
                  remaining_in = tick_e.lit;
                  led_in = 1'b1;
               end else begin
                  remaining_in = tick_e.dark;
                  led_in = 1'b0;
               end
            end else begin
               phase_in = step_phase;
               case (step_phase)
                  PHASE_PULSE1, PHASE_PULSE2: begin
                     remaining_in = cfg.double_pulse_ticks;
                     led_in = 1'b1;
                  end
                  PHASE_GAP: begin
                     remaining_in = cfg.double_gap_ticks;
                     led_in = 1'b0;
                  end
                  default: begin
                     // long gap is four times the table off time
                     remaining_in = {tick_e.dark[TICKS_W-3:0], 2'b00};
                     led_in = 1'b0;
                  end
               endcase
            end
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (item_take) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
         index_ff <= PAT_INIT;
         phase_ff <= PHASE_GAP;
         remaining_ff <= '0;
         fault_ff <= 1'b0;
         led_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pvalid_ff <= pvalid_in;
         index_ff <= index_in;
         phase_ff <= phase_in;
         remaining_ff <= remaining_in;
         fault_ff <= fault_in;
         led_ff <= led_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         out_led_ff <= led_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_led = out_led_ff;

endmodule

/* hdl/status_led_pattern_generator_core.sv */
// Status LED pattern generator. Each request transaction is either a one-millisecond tick
// (tuser 0) or a door state and fault update (tuser 1); every transaction returns one response
// carrying the LED level after it. The block takes one transaction per clock while the response
// side is not stalled; each response passes through the input register, then through the pattern
// next-state logic into the result register. The response side may stall; the input side keeps
// accepting until both registers hold data. Configuration writes are meant for idle periods only.
// top level; depends on slpg_pkg, slpg_csr, slpg_in_reg and slpg_pattern
module status_led_pattern_generator_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [slpg_pkg::DATA_BYTES_W-1:0] req_tdata,  // door_state[3:0], fault_flag[4]
   input  logic                             req_tuser,  // req_type
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [slpg_pkg::DATA_BYTES_W-1:0] rsp_tdata,  // led_on[0]
   input  logic                             csr_we,
   input  logic [slpg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [slpg_pkg::TICKS_W-1:0]     csr_wdata
);
   import slpg_pkg::*;

   cfg_type  cfg;
   item_type req_item;
   item_type item;
   logic     item_valid;
   logic     item_take;
   logic     rsp_led;

   assign req_item.req_type = req_tuser;
   assign req_item.door_state = req_tdata[3:0];
   assign req_item.fault_flag = req_tdata[4];

   slpg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   slpg_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   slpg_pattern u_pattern (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_led    (rsp_led)
   );

   assign rsp_tdata = {{(DATA_BYTES_W-1){1'b0}}, rsp_led};

endmodule

/* hdl/slpg_checker.sv */
// port-level checks for the status led pattern generator, bound to the top level
// depends on slpg_pkg and status_led_pattern_generator_core
module slpg_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [slpg_pkg::DATA_BYTES_W-1:0] req_tdata,
   input logic                             req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [slpg_pkg::DATA_BYTES_W-1:0] rsp_tdata
);
   import slpg_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // padding bits stay zero
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[DATA_BYTES_W-1:1] == '0))
      else $error("response padding not zero");

   // an empty result register never blocks the input side
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !$past(reset) |-> req_tready)
      else $error("input stalled while result register empty");

   // with no response pending, an accepted transaction reaches the output
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> ##1 rsp_tvalid)
      else $error("response missing after accepted transaction");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   logic unused_ok;
   assign unused_ok = ^{req_tdata, req_tuser};

endmodule

bind status_led_pattern_generator_core slpg_checker u_slpg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
